FILE: rtl/ps2he_pkg.sv
// Package: shared types and constants of the PS/2 host edge engine.
`default_nettype none
package ps2he_pkg;

    typedef enum logic [1:0] {
        FUNC_EDGE  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_TX    = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    localparam int CFG_W = 24;

    typedef enum logic [0:0] {
        CFG_GLITCH  = 1'b0,
        CFG_TIMEOUT = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] GLITCH_RESET  = 24'd8000;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 24'd19200;

    localparam logic [3:0] RX_FRAME_BITS  = 4'd11;
    localparam logic [3:0] TX_RELEASE_POS = 4'd10;

    localparam logic [7:0] CODE_E0 = 8'hE0;
    localparam logic [7:0] CODE_E1 = 8'hE1;
    localparam logic [7:0] CODE_F0 = 8'hF0;
    localparam logic [7:0] CODE_FA = 8'hFA;
    localparam logic [7:0] CODE_FE = 8'hFE;
    localparam logic [7:0] CODE_AA = 8'hAA;

    localparam int PFX_E0 = 0;
    localparam int PFX_E1 = 1;
    localparam int PFX_F0 = 2;

    localparam int RPL_ACK    = 0;
    localparam int RPL_RESEND = 1;
    localparam int RPL_SELF   = 2;

    typedef struct packed {
        t_func       func;
        logic [31:0] edge_time;
        logic        data_pin;
        logic [7:0]  tx_byte;
        logic [2:0]  clear_mask;
    } t_in_word;

    typedef struct packed {
        logic        drive_enable;
        logic        drive_level;
        logic        key_valid;
        logic [15:0] key_code;
        logic        ack_seen;
        logic        resend_seen;
        logic        selftest_seen;
        logic        tx_busy;
        logic        queue_overflow;
    } t_out_word;

endpackage
`default_nettype wire

FILE: rtl/ps2he_if.sv
// Interfaces: valid/ready channels for event words and result words.
`default_nettype none
interface ps2he_in_if import ps2he_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ps2he_out_if import ps2he_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ps2he_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ps2he_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ps2_host_edge_engine.sv
// Top level: PS/2 host edge engine, one event word in, one result word out.
//
// Event words arrive on i_in (valid/ready); each is one of: clock falling
// edge, read key, start transmit, clear reply flags. Every accepted event
// word yields exactly one result word on o_out, taken from the output
// register, which is loaded on acceptance. One event word per cycle is taken
// while o_out is free or being emptied; the output register and the key
// queue read register set this single-cycle rate.
// If o_out stalls, i_in.ready drops and the result word holds.
// Key codes sit in a QUEUE_DEPTH-entry RAM; a read pops the oldest code,
// an empty queue returns key_valid 0 and code 0, a full queue drops the
// new code and sets the sticky overflow flag.
// Configuration: i_cfg_we with i_cfg_addr 0 (glitch limit) or 1 (timeout)
// and i_cfg_wdata; the user must write only while idle, the block does not enforce it.
// Synchronous active-low reset clears all state, the queue pointers and
// the output register, and restores the glitch limit to 8000 and the
// timeout to 19200. Queue contents need no clearing.
`default_nettype none
module ps2_host_edge_engine import ps2he_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    ps2he_in_if.sink              i_in,
    ps2he_out_if.source           o_out
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    logic [CFG_W-1:0] r_glitch;
    logic [CFG_W-1:0] r_timeout;

    logic [31:0]   r_last_time, n_last_time;
    logic [10:0]   r_rx_frame, n_rx_frame;
    logic [3:0]    r_rx_bits, n_rx_bits;
    logic [8:0]    r_tx_frame, n_tx_frame;
    logic [3:0]    r_tx_pos, n_tx_pos;
    logic [2:0]    r_prefix, n_prefix;
    logic [2:0]    r_reply, n_reply;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_overflow, n_overflow;
    logic          r_out_valid;
    logic          r_key_valid, n_key_valid;

    logic          in_fire;
    t_in_word      in_word;
    logic [31:0]   dt;
    logic [7:0]    rx_code;
    logic          frame_ok;
    logic [15:0]   packed_code;
    logic          push_we;
    logic          pop_re;
    logic [15:0]   ram_rdata;
    logic [3:0]    tx_idx;
    logic          drive_en;
    logic          drive_lvl;

    assign in_word   = i_in.data;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire   = i_in.valid && i_in.ready;
    assign dt        = in_word.edge_time - r_last_time;

    always_comb begin
        n_last_time = r_last_time;
        n_rx_frame  = r_rx_frame;
        n_rx_bits   = r_rx_bits;
        n_tx_frame  = r_tx_frame;
        n_tx_pos    = r_tx_pos;
        n_prefix    = r_prefix;
        n_reply     = r_reply;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_key_valid = 1'b0;
        push_we     = 1'b0;
        pop_re      = 1'b0;
        rx_code     = '0;
        frame_ok    = 1'b0;
        packed_code = '0;

        unique case (in_word.func)
            FUNC_EDGE: begin
                if (dt >= {8'd0, r_glitch}) begin
                    if (dt > {8'd0, r_timeout}) begin
                        n_rx_frame = '0;
                        n_rx_bits  = '0;
                    end
                    n_last_time = in_word.edge_time;
                    if (r_tx_pos != '0) begin
                        if (r_tx_pos >= TX_RELEASE_POS) begin
                            n_tx_frame = '0;
                            n_tx_pos   = '0;
                        end else begin
                            n_tx_pos = r_tx_pos + 4'd1;
                        end
                    end else begin
                        if (n_rx_bits < RX_FRAME_BITS && in_word.data_pin) begin
                            n_rx_frame[n_rx_bits] = 1'b1;
                        end
                        n_rx_bits = n_rx_bits + 4'd1;
                        if (n_rx_bits >= RX_FRAME_BITS) begin
                            rx_code  = n_rx_frame[8:1];
                            frame_ok = !n_rx_frame[0] && n_rx_frame[10]
                                       && ((^rx_code) ^ n_rx_frame[9]);
                            if (frame_ok) begin
                                if (rx_code == CODE_E0) begin
                                    n_prefix[PFX_E0] = 1'b1;
                                end else if (rx_code == CODE_E1) begin
                                    n_prefix[PFX_E1] = 1'b1;
                                end else if (rx_code == CODE_F0) begin
                                    n_prefix[PFX_F0] = 1'b1;
                                end else if (rx_code == CODE_FA) begin
                                    n_reply[RPL_ACK] = 1'b1;
                                end else if (rx_code == CODE_FE) begin
                                    n_reply[RPL_RESEND] = 1'b1;
                                end else if (rx_code == CODE_AA) begin
                                    n_reply[RPL_SELF] = 1'b1;
                                end else begin
                                    packed_code = {r_prefix[PFX_F0], 5'd0,
                                                   r_prefix[PFX_E1] && !r_prefix[PFX_E0],
                                                   r_prefix[PFX_E0], rx_code};
                                    if (r_count < CNT_FULL) begin
                                        push_we = 1'b1;
                                        n_head  = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                                        n_count = r_count + 1'b1;
                                    end else begin
                                        n_overflow = 1'b1;
                                    end
                                    n_prefix = '0;
                                end
                            end
                            n_rx_frame = '0;
                            n_rx_bits  = '0;
                        end
                    end
                end
            end
            FUNC_READ: begin
                if (r_count != '0) begin
                    pop_re      = 1'b1;
                    n_tail      = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                    n_count     = r_count - 1'b1;
                    n_key_valid = 1'b1;
                end
            end
            FUNC_TX: begin
                n_tx_frame = {~(^in_word.tx_byte), in_word.tx_byte};
                n_tx_pos   = 4'd1;
            end
            FUNC_CLEAR: begin
                n_reply = r_reply & ~in_word.clear_mask;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch  <= GLITCH_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_GLITCH:  r_glitch  <= i_cfg_wdata;
                CFG_TIMEOUT: r_timeout <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_rx_frame  <= '0;
            r_rx_bits   <= '0;
            r_tx_frame  <= '0;
            r_tx_pos    <= '0;
            r_prefix    <= '0;
            r_reply     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_last_time <= n_last_time;
                r_rx_frame  <= n_rx_frame;
                r_rx_bits   <= n_rx_bits;
                r_tx_frame  <= n_tx_frame;
                r_tx_pos    <= n_tx_pos;
                r_prefix    <= n_prefix;
                r_reply     <= n_reply;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_overflow  <= n_overflow;
                r_key_valid <= n_key_valid;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    ps2he_ram #(
        .WIDTH (16),
        .DEPTH (QUEUE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && push_we),
        .i_waddr (r_head),
        .i_wdata (packed_code),
        .i_re    (in_fire && pop_re),
        .i_raddr (r_tail),
        .o_rdata (ram_rdata)
    );

    assign tx_idx    = r_tx_pos - 4'd2;
    assign drive_en  = (r_tx_pos != '0);
    assign drive_lvl = (r_tx_pos >= 4'd2 && r_tx_pos <= TX_RELEASE_POS)
                       ? r_tx_frame[tx_idx] : 1'b0;

    assign o_out.valid               = r_out_valid;
    assign o_out.data.drive_enable   = drive_en;
    assign o_out.data.drive_level    = drive_lvl;
    assign o_out.data.key_valid      = r_key_valid;
    assign o_out.data.key_code       = r_key_valid ? ram_rdata : 16'd0;
    assign o_out.data.ack_seen       = r_reply[RPL_ACK];
    assign o_out.data.resend_seen    = r_reply[RPL_RESEND];
    assign o_out.data.selftest_seen  = r_reply[RPL_SELF];
    assign o_out.data.tx_busy        = drive_en;
    assign o_out.data.queue_overflow = r_overflow;

endmodule
`default_nettype wire

FILE: tb/sv/ps2he_score_pkg.sv
// Scoreboard for the PS/2 host edge engine: event predictor and result word check.
`timescale 1ns / 1ps
package ps2he_score_pkg;
    import ps2he_pkg::*;

    localparam int KEY_DEPTH = 16;

    class ps2_edge_scoreboard;
        logic [CFG_W-1:0] glitch_min;
        logic [CFG_W-1:0] timeout_max;
        logic [31:0]      last_edge;
        logic [10:0]      rx_shift;
        logic [3:0]       rx_count;
        logic [8:0]       tx_shift;
        logic [3:0]       tx_pos;
        logic [2:0]       prefix;
        logic [2:0]       reply;
        logic [15:0]      keys [KEY_DEPTH];
        logic [3:0]       head;
        logic [3:0]       tail;
        logic [4:0]       count;
        logic             overflow;
        t_out_word        expected_q[$];
        int unsigned      mismatches;
        int unsigned      events;
        int unsigned      results;
        int unsigned      keys_read;
        int unsigned      codes_queued;
        int unsigned      codes_dropped;

        function new();
            glitch_min    = GLITCH_RESET;
            timeout_max   = TIMEOUT_RESET;
            last_edge     = '0;
            rx_shift      = '0;
            rx_count      = '0;
            tx_shift      = '0;
            tx_pos        = '0;
            prefix        = '0;
            reply         = '0;
            head          = '0;
            tail          = '0;
            count         = '0;
            overflow      = 1'b0;
            mismatches    = 0;
            events        = 0;
            results       = 0;
            keys_read     = 0;
            codes_queued  = 0;
            codes_dropped = 0;
        endfunction

        function void set_limits(logic [CFG_W-1:0] glitch, logic [CFG_W-1:0] timeout);
            glitch_min  = glitch;
            timeout_max = timeout;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void decode_frame();
            logic [7:0]  code;
            logic [15:0] key_word;
            code = rx_shift[8:1];
            if (rx_shift[0] || !rx_shift[10] || ((^code) ^ rx_shift[9]) != 1'b1) return;
            case (code)
                CODE_E0: prefix[PFX_E0] = 1'b1;
                CODE_E1: prefix[PFX_E1] = 1'b1;
                CODE_F0: prefix[PFX_F0] = 1'b1;
                CODE_FA: reply[RPL_ACK] = 1'b1;
                CODE_FE: reply[RPL_RESEND] = 1'b1;
                CODE_AA: reply[RPL_SELF] = 1'b1;
                default: begin
                    key_word = {8'h00, code};
                    if (prefix[PFX_E0]) key_word[8] = 1'b1;
                    else if (prefix[PFX_E1]) key_word[9] = 1'b1;
                    if (prefix[PFX_F0]) key_word[15] = 1'b1;
                    if (count >= KEY_DEPTH) begin
                        overflow = 1'b1;
                        codes_dropped++;
                    end else begin
                        keys[head] = key_word;
                        head++;
                        count++;
                        codes_queued++;
                    end
                    prefix = '0;
                end
            endcase
        endfunction

        function void clock_edge(logic [31:0] stamp, logic pin);
            logic [31:0] gap;
            gap = stamp - last_edge;
            if (gap < {8'h00, glitch_min}) return;
            if (gap > {8'h00, timeout_max}) begin
                rx_shift = '0;
                rx_count = '0;
            end
            last_edge = stamp;
            if (tx_pos != 0) begin
                if (tx_pos >= TX_RELEASE_POS) begin
                    tx_shift = '0;
                    tx_pos   = '0;
                end else begin
                    tx_pos++;
                end
                return;
            end
            if (pin) rx_shift[rx_count] = 1'b1;
            rx_count++;
            if (rx_count >= RX_FRAME_BITS) begin
                decode_frame();
                rx_shift = '0;
                rx_count = '0;
            end
        endfunction

        function void note_event(t_in_word w);
            t_out_word want;
            want = '0;
            events++;
            case (w.func)
                FUNC_EDGE: clock_edge(w.edge_time, w.data_pin);
                FUNC_READ: begin
                    if (count != 0) begin
                        want.key_valid = 1'b1;
                        want.key_code  = keys[tail];
                        tail++;
                        count--;
                        keys_read++;
                    end
                end
                FUNC_TX: begin
                    tx_shift = {~^w.tx_byte, w.tx_byte};
                    tx_pos   = 4'd1;
                end
                default: reply = reply & ~w.clear_mask;
            endcase
            want.drive_enable = (tx_pos != 0);
            want.tx_busy      = want.drive_enable;
            if (tx_pos >= 4'd2 && tx_pos <= TX_RELEASE_POS)
                want.drive_level = tx_shift[tx_pos - 4'd2];
            want.ack_seen       = reply[RPL_ACK];
            want.resend_seen    = reply[RPL_RESEND];
            want.selftest_seen  = reply[RPL_SELF];
            want.queue_overflow = overflow;
            expected_q.push_back(want);
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (expected_q.size() == 0) begin
                $error("result word with no event pending");
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            results++;
            compare("drive_enable", 16'(want.drive_enable), 16'(got.drive_enable));
            compare("drive_level", 16'(want.drive_level), 16'(got.drive_level));
            compare("key_valid", 16'(want.key_valid), 16'(got.key_valid));
            compare("key_code", want.key_code, got.key_code);
            compare("ack_seen", 16'(want.ack_seen), 16'(got.ack_seen));
            compare("resend_seen", 16'(want.resend_seen), 16'(got.resend_seen));
            compare("selftest_seen", 16'(want.selftest_seen), 16'(got.selftest_seen));
            compare("tx_busy", 16'(want.tx_busy), 16'(got.tx_busy));
            compare("queue_overflow", 16'(want.queue_overflow), 16'(got.queue_overflow));
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_ps2_host_edge_engine.sv
// Testbench top: drives event words into the PS/2 host edge engine and checks every result.
`timescale 1ns / 1ps
module tb_ps2_host_edge_engine;
    import ps2he_pkg::*;
    import ps2he_score_pkg::*;

    localparam int QUIET_LIMIT = 400;

    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_STOP,
        FLAW_PARITY
    } t_flaw;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             no_idle = 1'b0;
    int unsigned      quiet_cycles = 0;
    int unsigned      items_sent = 0;
    int unsigned      settings_count = 0;
    ps2_edge_scoreboard board;

    ps2he_in_if  ev_if ();
    ps2he_out_if res_if ();

    ps2_host_edge_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (ev_if.sink),
        .o_out       (res_if.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ps2_host_edge_engine test failed");
            $finish;
        end
    end

    function automatic t_in_word filler(t_func f);
        t_in_word w;
        w.func       = f;
        w.edge_time  = $urandom();
        w.data_pin   = 1'($urandom_range(0, 1));
        w.tx_byte    = 8'($urandom_range(0, 255));
        w.clear_mask = 3'($urandom_range(0, 7));
        return w;
    endfunction

    function automatic logic [7:0] plain_code();
        logic [7:0] code;
        code = 8'($urandom_range(0, 255));
        while (code == CODE_E0 || code == CODE_E1 || code == CODE_F0 ||
               code == CODE_FA || code == CODE_FE || code == CODE_AA)
            code = 8'($urandom_range(0, 255));
        return code;
    endfunction

    function automatic logic [31:0] kept_gap();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = {8'h00, board.glitch_min};
        hi = {8'h00, board.timeout_max};
        if (lo > hi) return lo + $urandom_range(0, 20);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic logic [31:0] restart_gap();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = {8'h00, board.glitch_min};
        hi = {8'h00, board.timeout_max};
        return ((lo > hi) ? lo : hi + 32'd1) + $urandom_range(0, 1000);
    endfunction

    function automatic logic [31:0] glitch_gap();
        return $urandom_range({8'h00, board.glitch_min} - 32'd1, 0);
    endfunction

    task automatic push_event(t_in_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev_if.valid <= 1'b1;
        ev_if.data  <= w;
        do @(posedge i_clk); while (!ev_if.ready);
        board.note_event(w);
        items_sent++;
    endtask

    task automatic edge_after(logic [31:0] gap, logic pin);
        t_in_word w;
        w           = filler(FUNC_EDGE);
        w.edge_time = board.last_edge + gap;
        w.data_pin  = pin;
        push_event(w);
    endtask

    task automatic finish_tx();
        while (board.tx_pos != 0) begin
            if ($urandom_range(0, 7) == 0) edge_after(restart_gap(), 1'($urandom_range(0, 1)));
            else edge_after(kept_gap(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_frame(logic [7:0] code, t_flaw flaw);
        logic [10:0] bits;
        int          i;
        finish_tx();
        bits = {1'b1, ~^code, code, 1'b0};
        case (flaw)
            FLAW_START:  bits[0] = 1'b1;
            FLAW_STOP:   bits[10] = 1'b0;
            FLAW_PARITY: bits[9] = ~bits[9];
            default: ;
        endcase
        for (i = 0; i < 11; i++) begin
            if (i == 0 && board.rx_count != 0) edge_after(restart_gap(), bits[i]);
            else edge_after(kept_gap(), bits[i]);
            if (board.glitch_min != 0 && $urandom_range(0, 15) == 0)
                edge_after(glitch_gap(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_key();
        int         pick;
        logic [7:0] code;
        pick = $urandom_range(0, 6);
        if (pick == 1 || pick == 4 || pick == 6) send_frame(CODE_E0, FLAW_NONE);
        if (pick == 2 || pick == 5 || pick == 6) send_frame(CODE_E1, FLAW_NONE);
        if (pick >= 3 && pick <= 5) send_frame(CODE_F0, FLAW_NONE);
        code = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : plain_code();
        send_frame(code, FLAW_NONE);
    endtask

    task automatic send_tx();
        finish_tx();
        push_event(filler(FUNC_TX));
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(0, 9)) edge_after(kept_gap(), 1'($urandom_range(0, 1)));
            push_event(filler(FUNC_TX));
        end
        finish_tx();
    endtask

    task automatic send_noise();
        t_in_word w;
        w = filler(t_func'($urandom_range(0, 3)));
        if (w.func == FUNC_EDGE && $urandom_range(0, 1) == 0)
            w.edge_time = board.last_edge +
                          $urandom_range(0, 2 * {8'h00, board.glitch_min} + 2);
        push_event(w);
    endtask

    task automatic send_broken();
        finish_tx();
        if ($urandom_range(0, 1) == 0) begin
            send_frame(8'($urandom_range(0, 255)), t_flaw'($urandom_range(1, 3)));
        end else begin
            repeat ($urandom_range(1, 10)) edge_after(kept_gap(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random(int unsigned count);
        int unsigned target;
        int          pick;
        target = items_sent + count;
        while (items_sent < target) begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 35) send_key();
            else if (pick < 45) send_frame(($urandom_range(0, 2) == 0) ? CODE_FA :
                                           ($urandom_range(0, 1) == 0) ? CODE_FE : CODE_AA,
                                           FLAW_NONE);
            else if (pick < 65) repeat ($urandom_range(1, 3)) push_event(filler(FUNC_READ));
            else if (pick < 72) send_tx();
            else if (pick < 77) push_event(filler(FUNC_CLEAR));
            else if (pick < 85) send_broken();
            else send_noise();
        end
        no_idle = 1'b0;
    endtask

    task automatic quiesce();
        ev_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic retune(logic [CFG_W-1:0] glitch, logic [CFG_W-1:0] timeout);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_GLITCH;
        cfg_wdata <= glitch;
        @(posedge i_clk);
        cfg_addr  <= CFG_TIMEOUT;
        cfg_wdata <= timeout;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        board.set_limits(glitch, timeout);
        settings_count++;
    endtask

    task automatic fill_queue();
        while (board.count < KEY_DEPTH) send_frame(plain_code(), FLAW_NONE);
        repeat (2) send_key();
        repeat (KEY_DEPTH + 1) push_event(filler(FUNC_READ));
    endtask

    task automatic run_directed();
        t_in_word w;
        push_event(filler(FUNC_READ));
        w = filler(FUNC_CLEAR);
        w.clear_mask = 3'b111;
        push_event(w);
        w = filler(FUNC_TX);
        w.tx_byte = 8'hFF;
        push_event(w);
        edge_after(kept_gap(), 1'b0);
        w = filler(FUNC_TX);
        w.tx_byte = 8'h00;
        push_event(w);
        edge_after(restart_gap(), 1'b1);
        finish_tx();
        edge_after(glitch_gap(), 1'b1);
        send_frame(8'h1C, FLAW_NONE);
        send_frame(8'h1C, FLAW_PARITY);
        push_event(filler(FUNC_READ));
        push_event(filler(FUNC_READ));
    endtask

    initial begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            board.check_result(res_if.data);
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] glitch_pick;
        board = new();
        i_rst_n     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_addr    <= CFG_GLITCH;
        cfg_wdata   <= '0;
        ev_if.valid <= 1'b0;
        ev_if.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(200);
        retune('0, '0);
        run_random(100);
        retune({CFG_W{1'b1}}, {CFG_W{1'b1}});
        run_random(150);
        retune('0, {CFG_W{1'b1}});
        run_random(100);
        fill_queue();
        glitch_pick = CFG_W'($urandom_range(1, 50));
        retune(glitch_pick, glitch_pick + CFG_W'($urandom_range(0, 100)));
        run_random(200);
        retune(CFG_W'(300), CFG_W'(100));
        run_random(100);
        retune(GLITCH_RESET, TIMEOUT_RESET);
        run_random(100);
        quiesce();

        $display("checked %0d result words for %0d events: %0d codes queued, %0d dropped, %0d read",
                 board.results, board.events, board.codes_queued, board.codes_dropped,
                 board.keys_read);
        $display("ran %0d limit settings beyond reset, zero and full-scale among them",
                 settings_count);
        if (board.mismatches == 0) begin
            $display("ps2_host_edge_engine test passed");
        end else begin
            $display("ps2_host_edge_engine test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/ps2he_pkg.sv
rtl/ps2he_if.sv
rtl/ps2he_ram.sv
rtl/ps2_host_edge_engine.sv
tb/sv/ps2he_score_pkg.sv
tb/sv/tb_ps2_host_edge_engine.sv
